// ----- design/mks_pkg.sv -----
package mks_pkg;

    localparam int unsigned KEY_COUNT = 16;

    localparam logic [19:0] REFRACTORY_RESET = 20'd30000;
    localparam logic [7:0]  CODE_NONE        = 8'h00;
    localparam logic [7:0]  CODE_RELEASE     = 8'h72;  // 'r'

    typedef enum logic {
        ACT_SCAN = 1'b0,
        ACT_READ = 1'b1
    } mks_action_t;

    typedef struct packed {
        logic        action;
        logic [31:0] now_us;
        logic [15:0] column_lines;
    } mks_in_t;

    typedef struct packed {
        logic [7:0] key_code;
        logic       key_valid;
        logic [4:0] queue_level;
    } mks_out_t;

    // Row-major key map: '1' '2' '3' 'a' / '4' '5' '6' 'b' / '7' '8' '9' 'c' / 's' '0' 'p' 'd'
    function automatic logic [7:0] key_ascii(input logic [3:0] idx);
        logic [7:0] code;
        unique case (idx)
            4'd0:    code = 8'h31;
            4'd1:    code = 8'h32;
            4'd2:    code = 8'h33;
            4'd3:    code = 8'h61;
            4'd4:    code = 8'h34;
            4'd5:    code = 8'h35;
            4'd6:    code = 8'h36;
            4'd7:    code = 8'h62;
            4'd8:    code = 8'h37;
            4'd9:    code = 8'h38;
            4'd10:   code = 8'h39;
            4'd11:   code = 8'h63;
            4'd12:   code = 8'h73;
            4'd13:   code = 8'h30;
            4'd14:   code = 8'h70;
            4'd15:   code = 8'h64;
            default: code = CODE_NONE;
        endcase
        return code;
    endfunction

endpackage

// ----- design/mks_ram.sv -----
module mks_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/matrix_keypad_scanner.sv -----
// Channel   Direction  Payload           Handshake
// s_        in         mks_in_t          s_valid / s_ready
// m_        out        mks_out_t         m_valid / m_ready
// cfg_      in         refractory_us     cfg_wr_en (no wait)
//
// One transaction per cycle sustained while the output is not stalled; each
// result passes through the registered read of the event RAM and the output
// register behind it.
// Reset (aresetn low, synchronous) empties the queue, clears last code and
// deadline, and loads the refractory time with 30000 us.
// A stalled output holds the read stage, which in turn holds s_ready low.
module matrix_keypad_scanner #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              cfg_wr_en,
    input  logic [19:0]       cfg_wr_data,

    input  logic              s_valid,
    output logic              s_ready,
    input  mks_pkg::mks_in_t  s_data,

    output logic              m_valid,
    input  logic              m_ready,
    output mks_pkg::mks_out_t m_data
);

    import mks_pkg::*;

    localparam int unsigned PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);

    // Read stage: one transaction waiting for RAM data
    typedef struct packed {
        logic             valid;
        logic             hit;
        logic [4:0]       level;
        logic [PTR_W-1:0] addr;
    } rd_stage_t;

    logic [19:0]       refractory_reg;
    logic [7:0]        last_code_reg, last_code_next;
    logic [31:0]       deadline_reg, deadline_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    rd_stage_t         stage_reg, stage_next;
    logic              out_valid_reg;
    mks_out_t          out_reg;

    logic              s_fire;
    logic              advance;
    logic              is_read;
    logic              pop;
    logic              push;
    logic              later;
    logic [31:0]       time_diff;
    logic [3:0]        key_idx;
    logic              key_found;
    logic [7:0]        key_code;
    logic [7:0]        push_code;
    logic [PTR_W-1:0]  ram_rd_addr;
    logic [7:0]        ram_rd_data;

    // Output register frees when empty or taken; read stage moves into it
    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !stage_reg.valid || advance;
    assign s_fire  = s_valid && s_ready;
    assign is_read = (s_data.action == ACT_READ);

    // Wrapping signed compare: now strictly later than deadline
    assign time_diff = s_data.now_us - deadline_reg;
    assign later     = (time_diff != 32'd0) && !time_diff[31];

    // First pressed key in row-major order; lowest index wins
    always_comb begin
        key_idx   = 4'd0;
        key_found = 1'b0;
        for (int i = KEY_COUNT - 1; i >= 0; i--) begin
            if (!s_data.column_lines[i]) begin
                key_idx   = 4'(i);
                key_found = 1'b1;
            end
        end
    end

    assign key_code  = key_found ? key_ascii(key_idx) : CODE_NONE;
    assign push_code = key_found ? key_code : CODE_RELEASE;

    assign pop  = s_fire && is_read && (fill_reg != '0);
    assign push = s_fire && !is_read && later && (key_code != last_code_reg)
                  && (fill_reg < FILL_W'(QUEUE_DEPTH));

    always_comb begin
        last_code_next = last_code_reg;
        deadline_next  = deadline_reg;
        if (s_fire && !is_read && later) begin
            deadline_next = s_data.now_us;
            if (key_code != last_code_reg) begin
                last_code_next = key_code;
                deadline_next  = s_data.now_us + {12'd0, refractory_reg};
            end
        end
    end

    always_comb begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        fill_next   = fill_reg;
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                          : rd_ptr_reg + PTR_W'(1);
            fill_next   = fill_reg - FILL_W'(1);
        end
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                          : wr_ptr_reg + PTR_W'(1);
            fill_next   = fill_reg + FILL_W'(1);
        end
    end

    // Hold the read address while the stage stalls so the RAM output stays put
    assign ram_rd_addr = s_fire ? rd_ptr_reg : stage_reg.addr;

    always_comb begin
        stage_next = stage_reg;
        if (s_fire) begin
            stage_next.valid = 1'b1;
            stage_next.hit   = pop;
            stage_next.level = 5'(fill_next);
            stage_next.addr  = rd_ptr_reg;
        end else if (advance) begin
            stage_next.valid = 1'b0;
        end
    end

    mks_ram #(
        .WIDTH (8),
        .DEPTH (QUEUE_DEPTH)
    ) u_event_ram (
        .aclk    (aclk),
        .wr_en   (push),
        .wr_addr (wr_ptr_reg),
        .wr_data (push_code),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            refractory_reg <= REFRACTORY_RESET;
            last_code_reg  <= CODE_NONE;
            deadline_reg   <= 32'd0;
            rd_ptr_reg     <= '0;
            wr_ptr_reg     <= '0;
            fill_reg       <= '0;
            stage_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                refractory_reg <= cfg_wr_data;
            end
            last_code_reg <= last_code_next;
            deadline_reg  <= deadline_next;
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            fill_reg      <= fill_next;
            stage_reg     <= stage_next;
            if (advance) begin
                out_valid_reg <= stage_reg.valid;
            end
        end
    end

    // Payload of the output register; no reset needed
    always_ff @(posedge aclk) begin
        if (advance && stage_reg.valid) begin
            out_reg.key_code    <= stage_reg.hit ? ram_rd_data : CODE_NONE;
            out_reg.key_valid   <= stage_reg.hit;
            out_reg.queue_level <= stage_reg.level;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

// ----- tb/tb_matrix_keypad_scanner.sv -----
module tb_matrix_keypad_scanner;
    import mks_pkg::*;

    localparam int unsigned QDEPTH       = 16;
    localparam int          STUCK_LIMIT  = 2000;  // cycles without any transaction
    localparam int          DRAIN_CYCLES = 8;     // well past the result path through the RAM read and output register

    // Key legend packed low key first: byte i is the ASCII code of key index row*4+col.
    localparam logic [16*8-1:0] KEY_LEGEND = "dp0sc987b654a321";

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [19:0] cfg_wr_data = '0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    mks_in_t     s_data      = '0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    mks_out_t    m_data;

    // Stimulus side: items waiting for the driver, idling switches per phase.
    mks_in_t     pending_items[$];
    int          src_hold_cnt  = 0;
    int          snk_stall_cnt = 0;
    bit          src_idle_on   = 1'b1;
    bit          snk_stall_on  = 1'b1;

    // Generator view of time, of the held column pattern and of the current setting.
    logic [31:0] gen_now      = '0;
    logic [15:0] gen_lines    = 16'hFFFF;
    logic [19:0] refr_setting = REFRACTORY_RESET;

    // Scanner shadow state, advanced on every accepted input transaction.
    logic [19:0] refr_model   = REFRACTORY_RESET;
    logic [7:0]  held_code    = CODE_NONE;
    logic [31:0] deadline_us  = '0;
    logic [7:0]  event_fifo[$];
    mks_out_t    expected_results[$];

    int          mismatch_count = 0;
    int          stuck_cycles   = 0;

    matrix_keypad_scanner #(
        .QUEUE_DEPTH(QDEPTH)
    ) i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Gap length: mostly none, often a few cycles, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Lowest-index pressed key (active low line) to ASCII, zero when nothing is pressed.
    function automatic logic [7:0] first_pressed(input logic [15:0] lines);
        logic [7:0] code;
        code = CODE_NONE;
        for (int k = 15; k >= 0; k--) begin
            if (!lines[k])
                code = KEY_LEGEND[k*8 +: 8];
        end
        return code;
    endfunction

    // Advance the shadow scanner by one transaction and return the result it owes.
    function automatic mks_out_t step_keypad(input mks_in_t item);
        mks_out_t    res;
        logic [31:0] diff;
        logic [7:0]  pressed;
        res = '0;
        if (item.action == ACT_READ) begin
            if (event_fifo.size() != 0) begin
                res.key_code  = event_fifo.pop_front();
                res.key_valid = 1'b1;
            end
        end else begin
            // Accept the tick only when now is strictly later, in wrapping signed terms.
            diff = item.now_us - deadline_us;
            if (diff != 0 && !diff[31]) begin
                deadline_us = item.now_us;
                pressed     = first_pressed(item.column_lines);
                if (pressed != held_code) begin
                    // Drop the event on a full queue but still track the key and deadline.
                    if (event_fifo.size() < QDEPTH)
                        event_fifo.push_back(pressed != CODE_NONE ? pressed : CODE_RELEASE);
                    held_code   = pressed;
                    deadline_us = item.now_us + {12'd0, refr_model};
                end
            end
        end
        res.queue_level = 5'(event_fifo.size());
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 64)
            $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task automatic push_scan(input logic [31:0] now, input logic [15:0] lines);
        mks_in_t item;
        item.action       = ACT_SCAN;
        item.now_us       = now;
        item.column_lines = lines;
        pending_items.push_back(item);
    endtask

    // Reads carry random time and lines; the scanner must ignore both.
    task automatic push_read();
        mks_in_t item;
        item.action       = ACT_READ;
        item.now_us       = $urandom;
        item.column_lines = 16'($urandom);
        pending_items.push_back(item);
    endtask

    // Hold until the driver is empty, every result is back, and the pipeline has settled.
    // Sample at the falling edge so the driver and monitor updates of the rising edge
    // are already visible.
    task automatic wait_idle();
        while (pending_items.size() != 0 || s_valid || expected_results.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Random traffic: press / hold / release sequences with time steps mostly
    // past the refractory window, plus early ticks, exact-deadline ticks,
    // large forward jumps, backward probes and noisy column patterns.
    task automatic gen_traffic(input int n_items, input int read_pct);
        int          r;
        logic [31:0] step;
        logic [31:0] probe;
        for (int n = 0; n < n_items; n++) begin
            if ($urandom_range(0, 99) < read_pct) begin
                push_read();
            end else begin
                r = $urandom_range(0, 99);
                if (r < 40)
                    gen_lines = ~(16'd1 << $urandom_range(0, 15));
                else if (r < 65)
                    gen_lines = 16'hFFFF;
                else if (r < 85)
                    gen_lines = gen_lines;
                else
                    gen_lines = 16'($urandom);

                r = $urandom_range(0, 99);
                if (r < 55)
                    step = refr_setting + 1 + $urandom_range(0, refr_setting / 8 + 20);
                else if (r < 70)
                    step = $urandom_range(0, refr_setting);
                else if (r < 80)
                    step = refr_setting;
                else if (r < 85)
                    step = $urandom_range(32'h4000_0000, 32'h7FFF_0000);
                else if (r < 92)
                    step = 0;
                else
                    step = 1;

                if (r >= 85 && r < 92) begin
                    // Backward probe: leave the generator clock where it is.
                    probe = gen_now - $urandom_range(1, 32'h7FFF_FFFF);
                    push_scan(probe, gen_lines);
                end else begin
                    gen_now = gen_now + step;
                    push_scan(gen_now, gen_lines);
                end
            end
        end
    endtask

    // Driver: present the next pending transaction whenever the slot is free,
    // inserting a random gap after each accepted one while source idling is on.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid      <= 1'b0;
            src_hold_cnt  = 0;
        end else if (!s_valid || s_ready) begin
            if (src_hold_cnt != 0) begin
                src_hold_cnt--;
                s_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                s_data       <= pending_items.pop_front();
                s_valid      <= 1'b1;
                src_hold_cnt  = src_idle_on ? pick_gap() : 0;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall at random while results are offered and sink stalls are on.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready       <= 1'b0;
            snk_stall_cnt  = 0;
        end else if (snk_stall_cnt != 0) begin
            snk_stall_cnt--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (snk_stall_on && m_valid)
                snk_stall_cnt = pick_gap();
        end
    end

    // Monitor: track register writes, predict on input transactions, then check
    // each output transaction against the oldest expectation.
    always @(posedge aclk) begin
        mks_out_t want;
        if (aresetn) begin
            if (cfg_wr_en)
                refr_model = cfg_wr_data;
            if (s_valid && s_ready)
                expected_results.push_back(step_keypad(s_data));
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result code=%h valid=%b level=%0d",
                        m_data.key_code, m_data.key_valid, m_data.queue_level));
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.key_code !== want.key_code)
                        report_mismatch($sformatf("key_code got %h want %h",
                            m_data.key_code, want.key_code));
                    if (m_data.key_valid !== want.key_valid)
                        report_mismatch($sformatf("key_valid got %b want %b",
                            m_data.key_valid, want.key_valid));
                    if (m_data.queue_level !== want.queue_level)
                        report_mismatch($sformatf("queue_level got %0d want %0d",
                            m_data.queue_level, want.queue_level));
                end
            end
        end
    end

    // Watchdog: count cycles in which neither channel moves a transaction.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial begin
        wait (stuck_cycles >= STUCK_LIMIT);
        $display("matrix_keypad_scanner regression: fail");
        $finish;
    end

    initial begin
        logic [15:0] lines;
        logic [19:0] refr;
        int          read_pct;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, run with the reset refractory time of 30000 us.
        push_read();                              // read from an empty queue
        push_scan(32'd0, 16'hFFFE);               // now equal to the deadline: ignored
        push_scan(32'h8000_0000, 16'hFFFE);       // half a wrap ahead: not later, ignored
        push_scan(32'd1, 16'hFFFE);               // first key change
        push_scan(32'd30001, 16'hFFFD);           // lands exactly on the new deadline
        // Walk every key once; lower keys released, higher keys random to test priority.
        for (int k = 1; k < 16; k++) begin
            lines = (16'($urandom) & ~((16'd1 << (k + 1)) - 16'd1)) | ((16'd1 << k) - 16'd1);
            push_scan(32'd1 + 32'd30001 * k, lines);
        end
        push_scan(32'd1 + 32'd30001 * 16, 16'hFFFF);  // release while the queue is full
        push_read();
        wait_idle();

        // Random phases: several refractory settings, including zero, the nominal
        // maximum and the full 20-bit value beyond it. Each phase drains before the
        // next write, which holds the sender until every result is back.
        gen_now = $urandom;
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: begin refr = 20'd30000;                read_pct = 25; end
                1: begin refr = 20'd0;                    read_pct = 30; end
                2: begin refr = 20'd1000000;              read_pct = 15; end
                3: begin refr = 20'hFFFFF;                read_pct = 45; end
                4: begin refr = 20'd1;                    read_pct = 25; end
                5: begin refr = 20'($urandom_range(2, 5000)); read_pct = 35; end
                6: begin refr = 20'($urandom);            read_pct = 10; end
                default: begin refr = REFRACTORY_RESET;   read_pct = 50; end
            endcase
            src_idle_on  = (p != 2 && p != 5);
            snk_stall_on = (p != 3 && p != 5);

            @(posedge aclk);
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= refr;
            @(posedge aclk);
            cfg_wr_en   <= 1'b0;
            refr_setting = refr;

            gen_traffic(170, read_pct);
            wait_idle();
        end

        if (mismatch_count == 0)
            $display("matrix_keypad_scanner regression: pass");
        else
            $display("matrix_keypad_scanner regression: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
design/mks_pkg.sv
design/mks_ram.sv
design/matrix_keypad_scanner.sv
tb/tb_matrix_keypad_scanner.sv
